[rtl/core/assert_macros.svh]
// Assertion macros used by the sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset.
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// Check that a condition implies another one in the cycle after it.
`define ASSERT_NEXT(label, clk, rst_n, cond, nxt, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
		else $error(msg);

`endif

[rtl/core/htt_pkg.sv]
// Shared types, constants and tables of the trajectory tracker.
`default_nettype none
package htt_pkg;
	localparam int TW = 13;
	localparam int CW = 18;
	localparam int VW = 24;
	localparam int GAIN_W = 20;
	localparam int IP_W = 10;
	localparam int RS_W = 16;
	localparam int CNT_W = 17;
	localparam int ANG_W = 16;
	localparam int CORDIC_STEPS = 14;
	localparam int PI_Q13 = 25736;
	localparam int VEL_SCALE = 35;
	localparam int TANH_SPAN = 16384;
	localparam logic signed [CW-1:0] CORDIC_GAIN = 18'sd39797;

	localparam logic [2:0] CFG_GAIN_X = 3'd0;
	localparam logic [2:0] CFG_GAIN_Y = 3'd1;
	localparam logic [2:0] CFG_GAIN_HEADING = 3'd2;
	localparam logic [2:0] CFG_INVERSE_PERIOD = 3'd3;
	localparam logic [2:0] CFG_RUN_STEPS = 3'd4;

	typedef struct packed {
		logic [GAIN_W-1:0] gain_x;
		logic [GAIN_W-1:0] gain_y;
		logic [GAIN_W-1:0] gain_heading;
		logic [IP_W-1:0] inverse_period;
		logic [RS_W-1:0] run_steps;
	} cfg_t;

	typedef struct packed {
		logic [VW-1:0] vel_x;
		logic [VW-1:0] vel_y;
		logic [VW-1:0] vel_ang;
		logic two;
	} res_t;

	function automatic logic signed [CW-1:0] atan_at(input logic [3:0] i);
		case (i)
			4'd0: return 18'sd8192;
			4'd1: return 18'sd4836;
			4'd2: return 18'sd2555;
			4'd3: return 18'sd1297;
			4'd4: return 18'sd651;
			4'd5: return 18'sd326;
			4'd6: return 18'sd163;
			4'd7: return 18'sd81;
			4'd8: return 18'sd41;
			4'd9: return 18'sd20;
			4'd10: return 18'sd10;
			4'd11: return 18'sd5;
			4'd12: return 18'sd3;
			4'd13: return 18'sd1;
			default: return '0;
		endcase
	endfunction
endpackage
`default_nettype wire

[rtl/core/htt_mul.sv]
// Shared signed multiplier with registered product.
`default_nettype none
module htt_mul #(
	parameter int MA = 32,
	parameter int MB = 24
) (
	input wire logic clk,
	input wire logic signed [MA-1:0] a,
	input wire logic signed [MB-1:0] b,
	output logic signed [MA+MB-1:0] p
);
	always_ff @(posedge clk) begin
		p <= a * b;
	end
endmodule
`default_nettype wire

[rtl/core/htt_cordic.sv]
// Iterative CORDIC for sine and cosine of the robot heading.
`default_nettype none
module htt_cordic (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic signed [htt_pkg::ANG_W-1:0] angle,
	output logic done,
	output logic signed [htt_pkg::CW-1:0] cos_o,
	output logic signed [htt_pkg::CW-1:0] sin_o
);
	import htt_pkg::*;

	logic signed [CW-1:0] x_q, y_q, z_q;
	logic [3:0] i_q;
	logic busy_q, flip_q;
	logic signed [CW-1:0] a_ext, a_adj, ys, xs;

	assign a_ext = CW'(angle);
	assign ys = y_q >>> i_q;
	assign xs = x_q >>> i_q;

	always_comb begin
		if (a_ext > 18'sd16384) begin
			a_adj = a_ext - 18'sd32768;
		end else if (a_ext < -18'sd16384) begin
			a_adj = a_ext + 18'sd32768;
		end else begin
			a_adj = a_ext;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			i_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			i_q <= '0;
		end else if (busy_q) begin
			if (i_q == 4'(CORDIC_STEPS - 1)) begin
				busy_q <= 1'b0;
			end
			i_q <= i_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= CORDIC_GAIN;
			y_q <= '0;
			z_q <= a_adj;
			flip_q <= (a_ext > 18'sd16384) || (a_ext < -18'sd16384);
		end else if (busy_q) begin
			if (z_q >= 0) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_at(i_q);
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_at(i_q);
			end
		end
	end

	assign done = !busy_q;
	assign cos_o = flip_q ? -x_q : x_q;
	assign sin_o = flip_q ? -y_q : y_q;
endmodule
`default_nettype wire

[rtl/core/htt_tanh_rom.sv]
// Constant tanh table over 0..4 with two read ports for interpolation.
`default_nettype none
module htt_tanh_rom #(
	parameter int DEPTH = 256,
	localparam int IW = $clog2(DEPTH + 1)
) (
	input wire logic [IW-1:0] addr,
	output logic [htt_pkg::TW-1:0] t0,
	output logic [htt_pkg::TW-1:0] t1
);
	import htt_pkg::*;

	localparam logic [63:0] ONE = 64'd1 << 30;

	function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
		logic [63:0] q;
		logic [63:0] r;
		q = '0;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[62:0], n[i]};
			if (r >= d) begin
				r = r - d;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic logic [(DEPTH+1)*TW-1:0] build_tab();
		logic [(DEPTH+1)*TW-1:0] tab;
		logic [63:0] y, term, r, e, den, v;
		tab = '0;
		y = udiv(64'd8 << 30, 64'(DEPTH));
		term = ONE;
		r = ONE;
		e = ONE;
		for (int n = 1; n <= 10; n++) begin
			term = udiv((term * y) >> 30, 64'(n));
			if (n % 2 == 1) begin
				r = r - term;
			end else begin
				r = r + term;
			end
		end
		for (int i = 0; i <= DEPTH; i++) begin
			den = ONE + e;
			v = udiv(((ONE - e) << 12) + (den >> 1), den);
			tab[i*TW +: TW] = v[TW-1:0];
			e = (e * r + (ONE >> 1)) >> 30;
		end
		return tab;
	endfunction

	localparam logic [(DEPTH+1)*TW-1:0] TAB = build_tab();

	logic [IW-1:0] addr1;

	assign addr1 = (addr == IW'(DEPTH)) ? addr : addr + 1'b1;
	assign t0 = TAB[TW*addr +: TW];
	assign t1 = TAB[TW*addr1 +: TW];
endmodule
`default_nettype wire

[rtl/core/htt_seq.sv]
// Step sequencer: feed-forward, tanh feedback, rotation and scaling on one multiplier.
`default_nettype none
`include "assert_macros.svh"
module htt_seq #(
	parameter int POS_BITS = 16,
	parameter int DEPTH = 256
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic func,
	input wire logic signed [POS_BITS-1:0] desired_x,
	input wire logic signed [POS_BITS-1:0] desired_y,
	input wire logic signed [htt_pkg::ANG_W-1:0] desired_heading,
	input wire logic signed [POS_BITS-1:0] robot_x,
	input wire logic signed [POS_BITS-1:0] robot_y,
	input wire logic signed [htt_pkg::ANG_W-1:0] robot_heading,
	input wire htt_pkg::cfg_t cfg,
	output logic res_valid,
	input wire logic res_ready,
	output htt_pkg::res_t res
);
	import htt_pkg::*;

	localparam int DW = POS_BITS + 1;
	localparam int FFW = DW + IP_W + 1;
	localparam int HW = ((FFW > 26) ? FFW : 26) + 1;
	localparam int MA = HW + 3;
	localparam int MB = 24;
	localparam int PW = MA + MB;
	localparam int EW = (DW > 15) ? DW : 15;
	localparam int IW = $clog2(DEPTH + 1);
	localparam logic signed [PW-1:0] SMAX = PW'(8388607);
	localparam logic signed [PW-1:0] SMIN = -SMAX - PW'(1);

	localparam logic [4:0] S_FFX = 5'd0, S_FFY = 5'd1, S_FFH = 5'd2, S_FFH2 = 5'd3;
	localparam logic [4:0] S_EX = 5'd4;
	localparam logic [4:0] S_X0 = 5'd5, S_X1 = 5'd6, S_X2 = 5'd7, S_X3 = 5'd8;
	localparam logic [4:0] S_Y0 = 5'd9, S_Y1 = 5'd10, S_Y2 = 5'd11, S_Y3 = 5'd12;
	localparam logic [4:0] S_EH = 5'd13;
	localparam logic [4:0] S_H0 = 5'd14, S_H1 = 5'd15, S_H2 = 5'd16, S_H3 = 5'd17;
	localparam logic [4:0] S_R0 = 5'd18, S_R1 = 5'd19, S_R2 = 5'd20, S_R3 = 5'd21;
	localparam logic [4:0] S_V0 = 5'd22, S_V1 = 5'd23;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CALC = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t state_q;
	logic [4:0] step_q;
	logic running_q;
	logic [CNT_W-1:0] count_q, count_n;
	logic signed [POS_BITS-1:0] prev_x_q, prev_y_q;
	logic signed [ANG_W-1:0] prev_h_q;
	logic signed [POS_BITS-1:0] dx_q, dy_q, rx_q, ry_q;
	logic signed [ANG_W-1:0] dh_q, rh_q;
	logic signed [HW-1:0] hx_q, hy_q, hw_q;
	logic signed [EW-1:0] e_q;
	logic [TW-1:0] t0_q;
	logic big_q;
	logic signed [PW-1:0] acc_q;
	logic signed [MA-1:0] ux_q, uy_q;
	logic [VW-1:0] vx_q, vy_q, va_q;

	logic signed [MA-1:0] mul_a;
	logic signed [MB-1:0] mul_b;
	logic signed [PW-1:0] p_q, p_r16, p_r8, p_r14, sum_r16, dif_r16;
	logic [EW-1:0] u;
	logic big;
	logic [IW-1:0] rom_addr;
	logic [TW-1:0] rom_t0, rom_t1, tmag;
	logic signed [TW:0] ts;
	logic [GAIN_W-1:0] gain_sel;
	logic signed [ANG_W-1:0] ffh_d, eh_d;
	logic cor_start, cor_done;
	logic signed [CW-1:0] cos_v, sin_v;
	logic accept, tick;

	htt_mul #(.MA(MA), .MB(MB)) u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(p_q));

	htt_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cor_start), .angle(robot_heading),
		.done(cor_done), .cos_o(cos_v), .sin_o(sin_v)
	);

	htt_tanh_rom #(.DEPTH(DEPTH)) u_rom (.addr(rom_addr), .t0(rom_t0), .t1(rom_t1));

	function automatic logic [VW-1:0] sat24(input logic signed [PW-1:0] v);
		if (v > SMAX) begin
			return 24'h7FFFFF;
		end else if (v < SMIN) begin
			return 24'h800000;
		end
		return v[VW-1:0];
	endfunction

	assign in_ready = (state_q == ST_IDLE);
	assign accept = in_valid && in_ready;
	assign tick = accept && func && running_q;
	assign cor_start = tick;

	assign p_r16 = (p_q + PW'(32768)) >>> 16;
	assign p_r8 = (p_q + PW'(128)) >>> 8;
	assign p_r14 = (p_q + PW'(8192)) >>> 14;
	assign sum_r16 = (acc_q + p_q + PW'(32768)) >>> 16;
	assign dif_r16 = (acc_q - p_q + PW'(32768)) >>> 16;
	assign ffh_d = dh_q - prev_h_q;
	assign eh_d = dh_q - rh_q;

	assign u = (e_q < 0) ? EW'(-e_q) : EW'(e_q);
	assign big = (u >= EW'(TANH_SPAN));
	assign rom_addr = big ? IW'(DEPTH) : p_q[14 +: IW];
	assign tmag = big_q ? t0_q : t0_q + p_r14[TW-1:0];
	assign ts = (e_q < 0) ? -$signed({1'b0, tmag}) : $signed({1'b0, tmag});
	assign count_n = count_q + 1'b1;

	always_comb begin
		unique case (step_q)
			S_X0, S_X1, S_X2, S_X3: gain_sel = cfg.gain_x;
			S_Y0, S_Y1, S_Y2, S_Y3: gain_sel = cfg.gain_y;
			default: gain_sel = cfg.gain_heading;
		endcase
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (state_q == ST_CALC) begin
			unique case (step_q)
				S_FFX: begin
					mul_a = MA'(DW'(dx_q) - DW'(prev_x_q));
					mul_b = MB'($signed({1'b0, cfg.inverse_period}));
				end
				S_FFY: begin
					mul_a = MA'(DW'(dy_q) - DW'(prev_y_q));
					mul_b = MB'($signed({1'b0, cfg.inverse_period}));
				end
				S_FFH: begin
					mul_a = MA'(ffh_d);
					mul_b = MB'($signed({1'b0, cfg.inverse_period}));
				end
				S_FFH2: begin
					mul_a = p_q[MA-1:0];
					mul_b = MB'(PI_Q13);
				end
				S_X0, S_Y0, S_H0: begin
					mul_a = MA'($signed({1'b0, u}));
					mul_b = MB'(DEPTH);
				end
				S_X1, S_Y1, S_H1: begin
					mul_a = MA'($signed({1'b0, rom_t1 - rom_t0}));
					mul_b = MB'($signed({1'b0, p_q[13:0]}));
				end
				S_X2, S_Y2, S_H2: begin
					mul_a = MA'(ts);
					mul_b = MB'($signed({1'b0, gain_sel}));
				end
				S_Y3: begin
					mul_a = MA'(eh_d);
					mul_b = MB'(PI_Q13);
				end
				S_H3: begin
					mul_a = MA'(hx_q);
					mul_b = MB'(cos_v);
				end
				S_R0: begin
					mul_a = MA'(hy_q);
					mul_b = MB'(sin_v);
				end
				S_R1: begin
					mul_a = MA'(hy_q);
					mul_b = MB'(cos_v);
				end
				S_R2: begin
					mul_a = MA'(hx_q);
					mul_b = MB'(sin_v);
				end
				S_R3: begin
					mul_a = ux_q;
					mul_b = MB'(VEL_SCALE);
				end
				S_V0: begin
					mul_a = uy_q;
					mul_b = MB'(VEL_SCALE);
				end
				default: begin
					mul_a = '0;
					mul_b = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			running_q <= 1'b0;
			count_q <= '0;
			prev_x_q <= '0;
			prev_y_q <= '0;
			prev_h_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && !func) begin
						running_q <= 1'b1;
						count_q <= '0;
						prev_x_q <= '0;
						prev_y_q <= '0;
						prev_h_q <= '0;
					end else if (tick) begin
						state_q <= ST_CALC;
						step_q <= '0;
					end
				end
				ST_CALC: begin
					if (step_q == S_V1) begin
						state_q <= ST_DONE;
					end
					step_q <= step_q + 5'd1;
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
						prev_x_q <= dx_q;
						prev_y_q <= dy_q;
						prev_h_q <= dh_q;
						if (count_n > CNT_W'(cfg.run_steps)) begin
							count_q <= '0;
							running_q <= 1'b0;
						end else begin
							count_q <= count_n;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (tick) begin
			dx_q <= desired_x;
			dy_q <= desired_y;
			dh_q <= desired_heading;
			rx_q <= robot_x;
			ry_q <= robot_y;
			rh_q <= robot_heading;
		end
		if (state_q == ST_CALC) begin
			unique case (step_q)
				S_FFY: hx_q <= p_q[HW-1:0];
				S_FFH: hy_q <= p_q[HW-1:0];
				S_EX: begin
					hw_q <= p_r16[HW-1:0];
					e_q <= EW'(DW'(dx_q) - DW'(rx_q));
				end
				S_X1, S_Y1, S_H1: begin
					t0_q <= rom_t0;
					big_q <= big;
				end
				S_X3: begin
					hx_q <= hx_q + p_r8[HW-1:0];
					e_q <= EW'(DW'(dy_q) - DW'(ry_q));
				end
				S_Y3: hy_q <= hy_q + p_r8[HW-1:0];
				S_EH: e_q <= p_r16[EW-1:0];
				S_H3: hw_q <= hw_q + p_r8[HW-1:0];
				S_R0: acc_q <= p_q;
				S_R1: ux_q <= sum_r16[MA-1:0];
				S_R2: acc_q <= p_q;
				S_R3: uy_q <= dif_r16[MA-1:0];
				S_V0: vx_q <= sat24(p_q);
				S_V1: begin
					vy_q <= sat24(p_q);
					va_q <= sat24(PW'(hw_q));
				end
				default: ;
			endcase
		end
	end

	assign res_valid = (state_q == ST_DONE);
	assign res.vel_x = vx_q;
	assign res.vel_y = vy_q;
	assign res.vel_ang = va_q;
	assign res.two = (count_n >= CNT_W'(cfg.run_steps));

	`ASSERT_AT(a_cordic_ready, clk, arst_n, (state_q == ST_CALC && step_q == S_H3) |-> cor_done, "cordic not finished before rotation")
	`ASSERT_NEXT(a_tick_starts, clk, arst_n, tick, (state_q == ST_CALC && step_q == S_FFX), "tick did not start the sequence")
	`ASSERT_NEXT(a_step_advance, clk, arst_n, (state_q == ST_CALC && step_q != S_V1), (state_q == ST_CALC && step_q == $past(step_q) + 5'd1), "step sequence broken")
endmodule
`default_nettype wire

[rtl/core/holonomic_trajectory_tracker.sv]
// Top level: configuration registers, stream unpacking and result output stage.
// A control tick shows its result after the step sequence, done state and output stage;
// a start item arms the tracker and gives no result. One item at a time: the next item is
// taken once the result is in the output stage, so a new tick waits until the last is through.
// The pace is set by the 24-step sequence on the one shared multiplier.
// Reset restores the default gains, period and run length, disarms and clears the
// previous reference; no clearing pass.
`default_nettype none
module holonomic_trajectory_tracker #(
	parameter int POS_BITS = 16,
	parameter int TANH_TABLE_DEPTH = 256,
	localparam int IN_W = ((4 * POS_BITS + 32 + 7) / 8) * 8
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	// desired_x, desired_y, desired_heading, robot_x, robot_y, robot_heading
	input wire logic [IN_W-1:0] s_tdata,
	// func
	input wire logic s_tuser,
	output logic m_tvalid,
	input wire logic m_tready,
	// vel_x, vel_y, vel_ang
	output logic [71:0] m_tdata,
	// is_stop
	output logic m_tuser,
	output logic m_tlast,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [2:0] cfg_index,
	input wire logic [19:0] cfg_data
);
	import htt_pkg::*;

	localparam int P = POS_BITS;

	cfg_t cfg_q;
	res_t res, out_q;
	logic res_valid, res_ready;
	logic out_valid_q, stop_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_x <= 20'd89600;
			cfg_q.gain_y <= 20'd89600;
			cfg_q.gain_heading <= 20'd2560;
			cfg_q.inverse_period <= 10'd10;
			cfg_q.run_steps <= 16'd1801;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_GAIN_X: cfg_q.gain_x <= cfg_data;
				CFG_GAIN_Y: cfg_q.gain_y <= cfg_data;
				CFG_GAIN_HEADING: cfg_q.gain_heading <= cfg_data;
				CFG_INVERSE_PERIOD: cfg_q.inverse_period <= cfg_data[IP_W-1:0];
				CFG_RUN_STEPS: cfg_q.run_steps <= cfg_data[RS_W-1:0];
				default: ;
			endcase
		end
	end

	htt_seq #(.POS_BITS(POS_BITS), .DEPTH(TANH_TABLE_DEPTH)) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.func(s_tuser),
		.desired_x(s_tdata[P-1:0]),
		.desired_y(s_tdata[2*P-1:P]),
		.desired_heading(s_tdata[2*P +: 16]),
		.robot_x(s_tdata[2*P+16 +: P]),
		.robot_y(s_tdata[3*P+16 +: P]),
		.robot_heading(s_tdata[4*P+16 +: 16]),
		.cfg(cfg_q),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res)
	);

	assign res_ready = !out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			stop_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
			stop_q <= 1'b0;
		end else if (out_valid_q && m_tready) begin
			if (!stop_q && out_q.two) begin
				stop_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b0;
				stop_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = stop_q ? 72'd0 : {out_q.vel_ang, out_q.vel_y, out_q.vel_x};
	assign m_tuser = stop_q;
	assign m_tlast = stop_q || !out_q.two;
endmodule
`default_nettype wire
